[rtl/core/hsb_pkg.sv]
// ----------------------------------------------------------------------------
// hsb_pkg
// Shared types and constants for the height source blend block.
// ----------------------------------------------------------------------------
package hsb_pkg;

  localparam int TILE_EDGE = 257;
  localparam int CNT_W     = $clog2(TILE_EDGE);
  localparam logic [CNT_W-1:0] EDGE_LAST = CNT_W'(TILE_EDGE - 1);

  localparam int H_W      = 16;
  localparam int COORD_W  = 32;
  localparam int WORLD_W  = COORD_W + 1;
  localparam int CFG_IDX_W = 4;

  // rounded division by 255: floor(x / 255) == (x * DIV_MUL) >> DIV_SHIFT for x < 2^24
  localparam int MAG_W     = 23;
  localparam int MUL_W     = 25;
  localparam logic [MUL_W-1:0] DIV_MUL = 25'd16843010;
  localparam int DIV_SHIFT = 32;
  localparam logic [MAG_W-1:0] DIV_RND = 23'd127;

  typedef enum logic [1:0] {
    MODE_REPLACE = 2'd0,
    MODE_ADD     = 2'd1,
    MODE_MIN     = 2'd2,
    MODE_MAX     = 2'd3
  } blend_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEND_MODE    = 4'd0,
    REG_STRENGTH      = 4'd1,
    REG_TILE_ORIGIN_X = 4'd2,
    REG_TILE_ORIGIN_Y = 4'd3,
    REG_REGION_MIN_X  = 4'd4,
    REG_REGION_MAX_X  = 4'd5,
    REG_REGION_MIN_Y  = 4'd6,
    REG_REGION_MAX_Y  = 4'd7
  } cfg_reg_e;

endpackage

[rtl/core/hsb_if.sv]
// ----------------------------------------------------------------------------
// hsb_if
// Valid/ready channels of the height source blend block.
// ----------------------------------------------------------------------------
interface hsb_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] current_height;
  logic signed [15:0] source_height;

  modport source (output valid, current_height, source_height, input ready);
  modport sink   (input valid, current_height, source_height, output ready);
endinterface

interface hsb_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] composed_height;
  logic               in_region;
  logic               overflow;
  logic               last_sample;

  modport source (output valid, composed_height, in_region, overflow, last_sample,
                  input ready);
  modport sink   (input valid, composed_height, in_region, overflow, last_sample,
                  output ready);
endinterface

interface hsb_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/height_source_blend.sv]
// ----------------------------------------------------------------------------
// height_source_blend
// Blends a source height into a raster-ordered tile inside a world rectangle.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          transaction
//  in_i     in   current_height, source_height                    one sample
//  out_o    out  composed_height, in_region, overflow, last_sample one result
//  cfg_i    in   index, data                                      register write
//
//  One sample per cycle sustained while out_o.ready is high; out_o.valid
//  rises after the input register, multiply, magnitude, divide-by-255
//  multiply and result register. Each stage holds its item only while the next
//  is full and stalled, so bubbles are squeezed out. Reset clears the tile
//  position and loads the register defaults. cfg_i is always ready.
// ----------------------------------------------------------------------------
module height_source_blend
  import hsb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  hsb_in_if.sink      in_i,
  hsb_out_if.source   out_o,
  hsb_cfg_if.sink     cfg_i
);

  // configuration
  logic [1:0]                mode_q;
  logic [7:0]                strength_q;
  logic signed [COORD_W-1:0] org_x_q, org_y_q;
  logic signed [COORD_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_REPLACE;
      strength_q <= 8'd255;
      org_x_q    <= '0;
      org_y_q    <= '0;
      min_x_q    <= '0;
      max_x_q    <= '0;
      min_y_q    <= '0;
      max_y_q    <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_BLEND_MODE:    mode_q     <= cfg_i.data[1:0];
        REG_STRENGTH:      strength_q <= cfg_i.data[7:0];
        REG_TILE_ORIGIN_X: org_x_q    <= cfg_i.data;
        REG_TILE_ORIGIN_Y: org_y_q    <= cfg_i.data;
        REG_REGION_MIN_X:  min_x_q    <= cfg_i.data;
        REG_REGION_MAX_X:  max_x_q    <= cfg_i.data;
        REG_REGION_MIN_Y:  min_y_q    <= cfg_i.data;
        REG_REGION_MAX_Y:  max_y_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // stage enables
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic en1, en2, en3, en4, eno;
  logic accept;

  assign eno = !vo_q || out_o.ready;
  assign en4 = !v4_q || eno;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;
  assign accept = in_i.valid && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (eno) vo_q <= v4_q;
    end
  end

  // tile position
  logic [CNT_W-1:0] col_q, row_q, col_d, row_d;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_q >= EDGE_LAST) begin
        col_d = '0;
        row_d = (row_q >= EDGE_LAST) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  logic signed [WORLD_W-1:0] gx, gy;
  logic in_rect, last;

  assign gx = $signed({org_x_q[COORD_W-1], org_x_q})
            + $signed({{(WORLD_W-CNT_W){1'b0}}, col_q});
  assign gy = $signed({org_y_q[COORD_W-1], org_y_q})
            + $signed({{(WORLD_W-CNT_W){1'b0}}, row_q});
  assign in_rect = (gx >= $signed({min_x_q[COORD_W-1], min_x_q}))
                && (gx <= $signed({max_x_q[COORD_W-1], max_x_q}))
                && (gy >= $signed({min_y_q[COORD_W-1], min_y_q}))
                && (gy <= $signed({max_y_q[COORD_W-1], max_y_q}));
  assign last = (col_q == EDGE_LAST) && (row_q == EDGE_LAST);

  // stage 1: input register
  logic signed [H_W-1:0] cur1_q, src1_q;
  logic                  in1_q, last1_q;

  // stage 2: products
  logic signed [H_W:0]   diff;
  logic signed [8:0]     s9;
  logic signed [25:0]    mprod;
  logic signed [24:0]    hprod;
  logic signed [24:0]    m2_q, h2_q;
  logic signed [H_W-1:0] cur2_q;
  logic                  in2_q, last2_q;

  assign diff  = $signed({src1_q[H_W-1], src1_q}) - $signed({cur1_q[H_W-1], cur1_q});
  assign s9    = $signed({1'b0, strength_q});
  assign mprod = diff * s9;
  assign hprod = src1_q * s9;

  // stage 3: magnitudes with rounding bias
  logic signed [25:0]    mix;
  logic [25:0]           mix_abs;
  logic [24:0]           h_abs;
  logic [MAG_W-1:0]      xa3_q, xb3_q;
  logic                  sa3_q, sb3_q;
  logic signed [H_W-1:0] cur3_q;
  logic                  in3_q, last3_q;

  assign mix = ($signed({{2{cur2_q[H_W-1]}}, cur2_q, 8'd0})
             -  $signed({{10{cur2_q[H_W-1]}}, cur2_q}))
             +  $signed({m2_q[24], m2_q});
  assign mix_abs = mix[25] ? 26'(-mix) : 26'(mix);
  assign h_abs   = h2_q[24] ? 25'(-h2_q) : 25'(h2_q);

  // stage 4: divide by 255
  logic [MAG_W+MUL_W-1:0] qa_prod, qb_prod;
  logic [H_W-1:0]         qa_mag, qb_mag;
  logic signed [H_W:0]    qa4_q, qb4_q;
  logic signed [H_W-1:0]  cur4_q;
  logic                   in4_q, last4_q;

  assign qa_prod = xa3_q * DIV_MUL;
  assign qb_prod = xb3_q * DIV_MUL;
  assign qa_mag  = qa_prod[DIV_SHIFT +: H_W];
  assign qb_mag  = qb_prod[DIV_SHIFT +: H_W];

  // output stage: mode and range check
  logic signed [H_W+1:0] cur_x, qa_x, qb_x, blend_v;
  logic                  ovf;

  assign cur_x = $signed({{2{cur4_q[H_W-1]}}, cur4_q});
  assign qa_x  = $signed({qa4_q[H_W], qa4_q});
  assign qb_x  = $signed({qb4_q[H_W], qb4_q});

  always_comb begin
    case (blend_mode_e'(mode_q))
      MODE_REPLACE: blend_v = qa_x;
      MODE_ADD:     blend_v = cur_x + qb_x;
      MODE_MIN:     blend_v = (cur_x < qb_x) ? cur_x : qb_x;
      MODE_MAX:     blend_v = (cur_x > qb_x) ? cur_x : qb_x;
      default:      blend_v = cur_x;
    endcase
  end

  assign ovf = in4_q && !(blend_v[H_W+1:H_W-1] inside {3'b000, 3'b111});

  logic signed [H_W-1:0] res_q;
  logic                  inr_q, ovf_q, lasto_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur1_q  <= in_i.current_height;
      src1_q  <= in_i.source_height;
      in1_q   <= in_rect;
      last1_q <= last;
    end
    if (en2 && v1_q) begin
      m2_q    <= mprod[24:0];
      h2_q    <= hprod;
      cur2_q  <= cur1_q;
      in2_q   <= in1_q;
      last2_q <= last1_q;
    end
    if (en3 && v2_q) begin
      xa3_q   <= mix_abs[MAG_W-1:0] + DIV_RND;
      xb3_q   <= h_abs[MAG_W-1:0] + DIV_RND;
      sa3_q   <= mix[25];
      sb3_q   <= h2_q[24];
      cur3_q  <= cur2_q;
      in3_q   <= in2_q;
      last3_q <= last2_q;
    end
    if (en4 && v3_q) begin
      qa4_q   <= sa3_q ? -$signed({1'b0, qa_mag}) : $signed({1'b0, qa_mag});
      qb4_q   <= sb3_q ? -$signed({1'b0, qb_mag}) : $signed({1'b0, qb_mag});
      cur4_q  <= cur3_q;
      in4_q   <= in3_q;
      last4_q <= last3_q;
    end
    if (eno && v4_q) begin
      res_q   <= (in4_q && !ovf) ? blend_v[H_W-1:0] : cur4_q;
      inr_q   <= in4_q;
      ovf_q   <= ovf;
      lasto_q <= last4_q;
    end
  end

  assign out_o.valid           = vo_q;
  assign out_o.composed_height = res_q;
  assign out_o.in_region       = inr_q;
  assign out_o.overflow        = ovf_q;
  assign out_o.last_sample     = lasto_q;

  // checks
  a_ovf_in_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && ovf_q |-> inr_q)
    else $error("overflow flagged outside region");

  a_tile_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && col_q == EDGE_LAST && row_q == EDGE_LAST |=> col_q == '0 && row_q == '0)
    else $error("tile position did not wrap");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= EDGE_LAST && row_q <= EDGE_LAST)
    else $error("tile position out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && !out_o.ready |=> vo_q && $stable(res_q))
    else $error("stalled result lost");

  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q && v3_q && v4_q && vo_q && !out_o.ready |-> !in_i.ready)
    else $error("accepted while pipeline full and stalled");

endmodule
